[rtl/d96r_pkg.sv]
// Package for the decimal96 integer rounding block.
// Holds the operation codes, widths and the per-limb cell interface types.
// No dependencies.
package d96r_pkg;

   localparam int DIGIT_WIDTH = 16;
   localparam int NUM_DIGITS = 6;
   localparam int SCALE_WIDTH = 8;
   localparam int OUT_SCALE_WIDTH = 5;
   localparam logic [SCALE_WIDTH-1:0] MAX_SCALE = 8'd28;

   // Reciprocal of ten for a value below 10 * 2^DIGIT_WIDTH: the quotient is
   // (value * DIV10_RECIP) >> DIV10_SHIFT.
   localparam logic [DIGIT_WIDTH+3:0] DIV10_RECIP = 20'd838861;
   localparam int DIV10_SHIFT = 23;

   typedef enum logic [1:0] {
      OP_TRUNCATE = 2'd0,
      OP_ROUND    = 2'd1,
      OP_FLOOR    = 2'd2,
      OP_NEGATE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_BUMP,
      ST_DONE
   } state_type;

   // Control from the sequencer to every limb cell.
   typedef struct packed {
      logic load;
      logic bump;
   } cell_ctrl_type;

endpackage

[rtl/d96r_limb_cell.sv]
// One 16-bit limb of the mantissa: divides by ten with the registered remainder from its
// upper neighbor and adds the carry from its lower neighbor. Depends on d96r_pkg.
module d96r_limb_cell import d96r_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [DIGIT_WIDTH-1:0] load_value,
   input  logic [3:0]             rem_from_upper,
   input  logic                   div_from_upper,
   output logic [3:0]             rem_to_lower,
   output logic                   div_to_lower,
   input  logic                   carry_from_lower,
   output logic                   carry_to_upper,
   output logic [DIGIT_WIDTH-1:0] limb
);

   logic [DIGIT_WIDTH-1:0]   limb_ff, limb_in;
   logic [3:0]               rem_ff, rem_in;
   logic                     div_ff;
   logic [DIGIT_WIDTH+3:0]   cur;
   logic [DIGIT_WIDTH+3:0]   tenq;
   logic [DIGIT_WIDTH+3:0]   diff;
   logic [2*DIGIT_WIDTH+7:0] prod;
   logic [DIGIT_WIDTH-1:0]   quot;
   logic [DIGIT_WIDTH:0]     sum;

   // cur is below 10 * 2^16, so the reciprocal product gives the exact quotient.
   assign cur = {rem_from_upper, limb_ff};
   assign prod = {{(DIGIT_WIDTH+4){1'b0}}, cur} * {{(DIGIT_WIDTH+4){1'b0}}, DIV10_RECIP};
   assign quot = prod[DIV10_SHIFT+DIGIT_WIDTH-1:DIV10_SHIFT];
   assign tenq = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
   assign diff = cur - tenq;
   assign rem_in = div_from_upper ? diff[3:0] : 4'd0;
   assign sum = {1'b0, limb_ff} + {{DIGIT_WIDTH{1'b0}}, carry_from_lower};
   assign carry_to_upper = sum[DIGIT_WIDTH];
   assign limb = limb_ff;
   assign rem_to_lower = rem_ff;
   assign div_to_lower = div_ff;

   always_comb begin
      limb_in = limb_ff;
      if (ctrl.load) begin
         limb_in = load_value;
      end else if (div_from_upper) begin
         limb_in = quot;
      end else if (ctrl.bump) begin
         limb_in = sum[DIGIT_WIDTH-1:0];
      end
   end

   // The division step and its remainder move one cell down per cycle.
   always_ff @(posedge clock) begin
      limb_ff <= limb_in;
      if (reset) begin
         div_ff <= 1'b0;
         rem_ff <= 4'd0;
      end else begin
         div_ff <= div_from_upper;
         rem_ff <= rem_in;
      end
   end

endmodule

[rtl/decimal96_integer_rounding.sv]
// Top level of the decimal96 integer rounding block: sequencer plus a row of
// six 16-bit limb cells through which each division by ten ripples. Depends on d96r_pkg.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_operation .. req_negative
//   rsp      out        rsp_valid, rsp_stall, rsp_out_mantissa_low .. rsp_error
//
// For truncate, round and floor with a scale s from 1 to 28, the sequencer issues s
// divisions by ten one after another, waits until the last one has left the row, then
// decides; an increment adds the bump state. Scale 0, negate and an invalid scale skip
// the divisions. One transaction is in work at a time; req_stall is high until the
// result is taken, and the next transaction can be accepted in the cycle after.
// Reset is synchronous and returns the sequencer to idle. The result holds while rsp_stall
// is high.
module decimal96_integer_rounding import d96r_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_operation,
   input  logic [63:0]                req_mantissa_low,
   input  logic [31:0]                req_mantissa_high,
   input  logic [SCALE_WIDTH-1:0]     req_decimal_scale,
   input  logic                       req_negative,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [63:0]                rsp_out_mantissa_low,
   output logic [31:0]                rsp_out_mantissa_high,
   output logic [OUT_SCALE_WIDTH-1:0] rsp_out_scale,
   output logic                       rsp_out_negative,
   output logic                       rsp_error
);

   state_type state_ff, state_in;
   logic [SCALE_WIDTH-1:0] count_ff, count_in;
   logic [SCALE_WIDTH-1:0] scale_ff, scale_in;
   op_type op_ff, op_in;
   logic neg_ff, neg_in;
   logic err_ff, err_in;
   logic any_rem_ff, any_rem_in;
   logic [3:0] last_rem_ff, last_rem_in;
   cell_ctrl_type ctrl;
   logic accept, bump_needed, div_issue, chain_busy;

   logic [NUM_DIGITS*DIGIT_WIDTH-1:0] mant_in;
   logic [NUM_DIGITS*DIGIT_WIDTH-1:0] mant_out;
   logic [DIGIT_WIDTH-1:0] limbs [NUM_DIGITS];
   logic [3:0] rems [NUM_DIGITS+1];
   logic tokens [NUM_DIGITS+1];
   logic carries [NUM_DIGITS+1];

   assign mant_in = {req_mantissa_high, req_mantissa_low};
   assign rems[NUM_DIGITS] = 4'd0;
   assign tokens[NUM_DIGITS] = div_issue;
   assign carries[0] = 1'b1;

   for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
      d96r_limb_cell u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .load_value(mant_in[g*DIGIT_WIDTH +: DIGIT_WIDTH]),
         .rem_from_upper(rems[g+1]),
         .div_from_upper(tokens[g+1]),
         .rem_to_lower(rems[g]),
         .div_to_lower(tokens[g]),
         .carry_from_lower(carries[g]),
         .carry_to_upper(carries[g+1]),
         .limb(limbs[g])
      );
   end

   always_comb begin
      chain_busy = 1'b0;
      mant_out = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         chain_busy = chain_busy | tokens[i];
         mant_out[i*DIGIT_WIDTH +: DIGIT_WIDTH] = limbs[i];
      end
   end

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      bump_needed = 1'b0;
      case (op_ff)
         OP_ROUND: bump_needed = (last_rem_ff >= 4'd5);
         OP_FLOOR: bump_needed = any_rem_ff && neg_ff;
         default:  bump_needed = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            // Decide only once the last remainder has left the row.
            if ((err_ff || op_ff == OP_NEGATE || count_ff == '0) && !chain_busy) begin
               state_in = bump_needed && !err_ff && op_ff != OP_NEGATE ? ST_BUMP : ST_DONE;
            end
         end
         ST_BUMP:   state_in = ST_DONE;
         ST_DONE:   if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      ctrl = '0;
      div_issue = 1'b0;
      count_in = count_ff;
      scale_in = scale_ff;
      op_in = op_ff;
      neg_in = neg_ff;
      err_in = err_ff;
      any_rem_in = any_rem_ff;
      last_rem_in = last_rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               count_in = req_decimal_scale;
               scale_in = req_decimal_scale;
               op_in = op_type'(req_operation);
               neg_in = req_negative;
               err_in = req_decimal_scale > MAX_SCALE;
               any_rem_in = 1'b0;
               last_rem_in = 4'd0;
            end
         end
         ST_DIVIDE: begin
            if (!err_ff && op_ff != OP_NEGATE && count_ff != '0) begin
               div_issue = 1'b1;
               count_in = count_ff - 1'b1;
            end
            // The bottom cell hands out the dropped digits in order.
            if (tokens[0]) begin
               last_rem_in = rems[0];
               any_rem_in = any_rem_ff || (rems[0] != 4'd0);
            end
         end
         ST_BUMP: ctrl.bump = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      scale_ff <= scale_in;
      op_ff <= op_in;
      neg_ff <= neg_in;
      err_ff <= err_in;
      any_rem_ff <= any_rem_in;
      last_rem_ff <= last_rem_in;
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_error = err_ff;
   assign rsp_out_mantissa_low = err_ff ? 64'd0 : mant_out[63:0];
   assign rsp_out_mantissa_high = err_ff ? 32'd0 : mant_out[95:64];
   assign rsp_out_scale = (err_ff || op_ff != OP_NEGATE) ? '0 : scale_ff[OUT_SCALE_WIDTH-1:0];
   assign rsp_out_negative = err_ff ? 1'b0 : (op_ff == OP_NEGATE ? !neg_ff : neg_ff);

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open while result pending");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      div_issue |=> count_ff == $past(count_ff) - 1'b1)
      else $error("scale counter did not step");
   a_bump_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BUMP |=> state_ff == ST_DONE) else $error("bump not followed by result");
   a_row_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !chain_busy) else $error("division step left in the row");

endmodule
